>>> src/tps_pkg.sv
// Shared types, codes and tone tables for the tone pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_PLAY  = 2'd1,
      REQ_ALERT = 2'd2,
      REQ_MUTE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ALERT_NONE = 2'd0,
      ALERT_WARN = 2'd1,
      ALERT_CRIT = 2'd2
   } alert_type;

   localparam logic [3:0]  MAX_PATTERN    = 4'd11;
   localparam logic [3:0]  SEQ_WARN       = 4'd12;
   localparam logic [3:0]  SEQ_CRIT       = 4'd13;
   localparam logic [31:0] WARN_PERIOD_MS = 32'd10000;
   localparam logic [31:0] CRIT_PERIOD_MS = 32'd4000;

   // Classified request as it waits between front and back.
   typedef struct packed {
      req_kind_type kind;
      logic [3:0]   pattern;
      logic         play_ok;
      alert_type    level;
      logic         mute_on;
   } req_cmd_type;

   typedef struct packed {
      logic        busy_res;
      logic        dropped;
      logic [3:0]  queue_count;
      logic        idle_level;
      logic [11:0] tone_hz;
   } rsp_fields_type;

   // First segment and segment count of each sequence; codes 12/13 are the alerts.
   localparam logic [5:0] SEQ_FIRST [16] = '{
      6'd0, 6'd1, 6'd6, 6'd10, 6'd13, 6'd14, 6'd22, 6'd32,
      6'd37, 6'd40, 6'd45, 6'd48, 6'd51, 6'd54, 6'd0, 6'd0};

   localparam logic [3:0] SEQ_COUNT [16] = '{
      4'd1, 4'd5, 4'd4, 4'd3, 4'd1, 4'd8, 4'd10, 4'd5,
      4'd3, 4'd5, 4'd3, 4'd3, 4'd3, 4'd5, 4'd1, 4'd1};

   localparam logic [11:0] SEG_HZ [64] = '{
      12'd1000,
      12'd1000, 12'd0, 12'd1300, 12'd0, 12'd1600,
      12'd500, 12'd0, 12'd500, 12'd0,
      12'd1200, 12'd0, 12'd1500,
      12'd800,
      12'd2000, 12'd0, 12'd2000, 12'd0, 12'd2000, 12'd0, 12'd2000, 12'd0,
      12'd300, 12'd0, 12'd300, 12'd0, 12'd300, 12'd0, 12'd300, 12'd0, 12'd300, 12'd0,
      12'd600, 12'd0, 12'd1000, 12'd0, 12'd1400,
      12'd2000, 12'd0, 12'd2500,
      12'd1500, 12'd0, 12'd1000, 12'd0, 12'd600,
      12'd1100, 12'd0, 12'd1300,
      12'd1200, 12'd0, 12'd900,
      12'd1400, 12'd0, 12'd1400,
      12'd400, 12'd0, 12'd400, 12'd0, 12'd400,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0};

   localparam logic [7:0] SEG_MS [64] = '{
      8'd50,
      8'd40, 8'd30, 8'd40, 8'd30, 8'd60,
      8'd50, 8'd50, 8'd50, 8'd50,
      8'd100, 8'd50, 8'd100,
      8'd150,
      8'd40, 8'd60, 8'd40, 8'd60, 8'd40, 8'd60, 8'd40, 8'd60,
      8'd80, 8'd40, 8'd80, 8'd40, 8'd80, 8'd40, 8'd80, 8'd40, 8'd80, 8'd40,
      8'd80, 8'd50, 8'd80, 8'd50, 8'd80,
      8'd50, 8'd50, 8'd50,
      8'd80, 8'd50, 8'd80, 8'd50, 8'd80,
      8'd50, 8'd30, 8'd60,
      8'd80, 8'd40, 8'd60,
      8'd70, 8'd60, 8'd70,
      8'd100, 8'd60, 8'd100, 8'd60, 8'd140,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

endpackage

`default_nettype wire

>>> src/tps_front.sv
// Request intake: classifies each request and holds it in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module tps_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [1:0]          in_kind,
   input  wire logic [7:0]          in_data,
   output logic                     q_valid,
   output tps_pkg::req_cmd_type     q_cmd,
   input  wire logic                q_pop
);
   import tps_pkg::*;

   localparam logic [1:0] SLOTS = 2'd2;

   req_cmd_type entry_ff [2];
   req_cmd_type cmd;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   always_comb begin
      cmd.kind    = req_kind_type'(in_kind);
      cmd.pattern = in_data[3:0];
      cmd.play_ok = in_data[3:0] <= MAX_PATTERN;
      cmd.mute_on = in_data[6];
      case (alert_type'(in_data[5:4]))
         ALERT_WARN: cmd.level = ALERT_WARN;
         ALERT_CRIT: cmd.level = ALERT_CRIT;
         default:    cmd.level = ALERT_NONE;
      endcase
   end

   assign in_ready = count_ff != SLOTS;
   assign q_valid  = count_ff != 2'd0;
   assign q_cmd    = entry_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

>>> src/tps_back.sv
// Sequencer core: pattern queue, alert scheduling, segment timing and result register.
`timescale 1ns / 1ps
`default_nettype none

module tps_back #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire tps_pkg::req_cmd_type cmd,
   output logic                      cmd_pop,
   input  wire logic                 active_low,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output tps_pkg::rsp_fields_type   out_fields
);
   import tps_pkg::*;

   localparam int HeadW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FillW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [HeadW-1:0] LastSlot = HeadW'(QUEUE_DEPTH - 1);
   localparam logic [FillW-1:0] FullFill = FillW'(QUEUE_DEPTH);

   function automatic logic [HeadW-1:0] next_slot(input logic [HeadW-1:0] h);
      return (h == LastSlot) ? '0 : h + 1'b1;
   endfunction

   function automatic logic [5:0] seg_addr(input logic [3:0] seq, input logic [3:0] idx);
      logic [6:0] s;
      s = {1'b0, SEQ_FIRST[seq]} + {3'b000, idx};
      return s[5:0];
   endfunction

   function automatic logic [31:0] alert_period(input alert_type lvl);
      case (lvl)
         ALERT_WARN: return WARN_PERIOD_MS;
         ALERT_CRIT: return CRIT_PERIOD_MS;
         default:    return 32'd0;
      endcase
   endfunction

   logic [3:0]       pattern_mem [QUEUE_DEPTH];
   logic [HeadW-1:0] head_ff, head_in;
   logic [HeadW-1:0] tail_ff, tail_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [3:0]       hd_ff, hd_in;
   logic [3:0]       rd_ff;
   logic [HeadW-1:0] rd_addr;
   logic [31:0]      ms_ff, ms_in;
   logic             muted_ff, muted_in;
   alert_type        alert_ff, alert_in;
   logic [31:0]      due_ff, due_in;
   logic [3:0]       seq_ff, seq_in;
   logic [3:0]       idx_ff, idx_in;
   logic [7:0]       left_ff, left_in;
   logic             busy_ff, busy_in;
   logic             turn_ff, turn_in;
   logic             out_valid_ff, out_valid_in;
   rsp_fields_type   out_ff, result;

   logic             fire;
   logic             wr_en;
   logic             adv;
   logic             drop;
   logic             push_empty;

   assign fire       = cmd_valid && (!out_valid_ff || out_ready);
   assign cmd_pop    = fire;
   assign out_valid  = out_valid_ff;
   assign out_fields = out_ff;

   always_comb begin
      logic [7:0]       left_dec;
      logic [3:0]       idx_nx;
      logic [FillW-1:0] fill_pre;
      logic [31:0]      diff;
      logic             due_now;
      logic [3:0]       start_code;
      logic             start;

      ms_in      = ms_ff;
      muted_in   = muted_ff;
      alert_in   = alert_ff;
      due_in     = due_ff;
      seq_in     = seq_ff;
      idx_in     = idx_ff;
      left_in    = left_ff;
      busy_in    = busy_ff;
      turn_in    = turn_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      wr_en      = 1'b0;
      adv        = 1'b0;
      drop       = 1'b0;
      push_empty = 1'b0;
      left_dec   = 8'd0;
      idx_nx     = 4'd0;
      fill_pre   = fill_ff;
      start      = 1'b0;
      start_code = 4'd0;

      case (cmd.kind)
         REQ_TICK: begin
            ms_in = ms_ff + 32'd1;
            if (busy_ff) begin
               left_dec = (left_ff != 8'd0) ? left_ff - 8'd1 : left_ff;
               left_in  = left_dec;
               if (left_dec == 8'd0) begin
                  idx_nx = idx_ff + 4'd1;
                  idx_in = idx_nx;
                  if (idx_nx >= SEQ_COUNT[seq_ff]) begin
                     busy_in = 1'b0;
                  end else begin
                     left_in = SEG_MS[seg_addr(seq_ff, idx_nx)];
                  end
               end
            end
         end
         REQ_PLAY: begin
            if (!muted_ff && cmd.play_ok) begin
               wr_en   = 1'b1;
               tail_in = next_slot(tail_ff);
               if (fill_ff == FullFill) begin
                  // full: push out the oldest entry
                  head_in  = next_slot(head_ff);
                  adv      = 1'b1;
                  drop     = 1'b1;
                  fill_pre = FullFill - 1'b1;
               end
               push_empty = fill_pre == '0;
               fill_in    = fill_pre + 1'b1;
            end
         end
         REQ_ALERT: begin
            if (cmd.level != alert_ff) begin
               alert_in = cmd.level;
               due_in   = ms_ff;
            end
         end
         REQ_MUTE: begin
            if (cmd.mute_on != muted_ff) begin
               muted_in = cmd.mute_on;
               if (cmd.mute_on) begin
                  head_in = '0;
                  tail_in = '0;
                  fill_in = '0;
                  busy_in = 1'b0;
                  left_in = 8'd0;
               end
            end
         end
         default: begin
         end
      endcase

      // idle: start the next alert or queued pattern right away
      diff    = ms_in - due_in;
      due_now = (alert_in != ALERT_NONE) && !diff[31];
      if (!busy_in) begin
         if (due_now && (turn_in || fill_in == '0)) begin
            due_in  = ms_in + alert_period(alert_in);
            turn_in = 1'b0;
            if (!muted_in) begin
               start      = 1'b1;
               start_code = (alert_in == ALERT_WARN) ? SEQ_WARN : SEQ_CRIT;
            end
         end else if (fill_in != '0 && !muted_in) begin
            start      = 1'b1;
            start_code = push_empty ? cmd.pattern : hd_ff;
            head_in    = next_slot(head_in);
            adv        = 1'b1;
            fill_in    = fill_in - 1'b1;
            turn_in    = 1'b1;
         end else begin
            turn_in = 1'b0;
         end
      end
      if (start) begin
         seq_in  = start_code;
         idx_in  = 4'd0;
         left_in = SEG_MS[SEQ_FIRST[start_code]];
         busy_in = 1'b1;
      end

      // keep the head entry on hand for the next pop
      if (wr_en && tail_ff == head_in) begin
         hd_in = cmd.pattern;
      end else if (adv) begin
         hd_in = rd_ff;
      end else begin
         hd_in = hd_ff;
      end
      rd_addr = next_slot(head_in);

      result.tone_hz     = busy_in ? SEG_HZ[seg_addr(seq_in, idx_in)] : 12'd0;
      result.idle_level  = muted_in | active_low;
      result.queue_count = 4'(fill_in);
      result.dropped     = drop;
      result.busy_res    = busy_in;

      out_valid_in = fire || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         ms_ff        <= 32'd0;
         muted_ff     <= 1'b0;
         alert_ff     <= ALERT_NONE;
         due_ff       <= 32'd0;
         seq_ff       <= 4'd0;
         idx_ff       <= 4'd0;
         left_ff      <= 8'd0;
         busy_ff      <= 1'b0;
         turn_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            fill_ff  <= fill_in;
            ms_ff    <= ms_in;
            muted_ff <= muted_in;
            alert_ff <= alert_in;
            due_ff   <= due_in;
            seq_ff   <= seq_in;
            idx_ff   <= idx_in;
            left_ff  <= left_in;
            busy_ff  <= busy_in;
            turn_ff  <= turn_in;
         end
      end
   end

   // pattern storage with one registered read port, bypassed on a same-slot write
   always_ff @(posedge clock) begin
      if (fire) begin
         if (wr_en) begin
            pattern_mem[tail_ff] <= cmd.pattern;
         end
         rd_ff  <= (wr_en && tail_ff == rd_addr) ? cmd.pattern : pattern_mem[rd_addr];
         hd_ff  <= hd_in;
         out_ff <= result;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_means_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> fill_ff == '0)
      else $error("sequencer idle with patterns still queued");

   a_muted_silent: assert property (@(posedge clock) disable iff (reset)
      muted_ff |-> (!busy_ff && fill_ff == '0))
      else $error("muted while playing or holding queued patterns");

   a_segment_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> left_ff != 8'd0)
      else $error("playing segment has no time left");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FullFill)
      else $error("pattern queue fill beyond depth");
`endif
endmodule

`default_nettype wire

>>> src/tone_pattern_sequencer.sv
// Top level of the buzzer tone pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Buzzer sequencer. Each request (a one-ms tick, a play, an alert level or a mute
// setting) returns exactly one response carrying the tone frequency in Hz, the idle pin
// level, the queued pattern count, a drop flag and a busy flag. Requests enter a
// two-entry queue and are executed one per clock by the sequencer core unless the
// response side stalls, so the block then sustains one request per cycle; a request
// passes the front queue and the core's result register before its response is valid,
// and the queue takes up to two more requests while a response waits. Play requests
// beyond QUEUE_DEPTH drop the oldest waiting pattern. No clearing pass runs after
// reset. Write csr_wdata (buzzer active low) only while no request is outstanding.
module tone_pattern_sequencer #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // pattern[3:0], alert_level[5:4], mute_on[6]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // tone_hz[11:0], idle_level[12],
                                         // queue_count[16:13], dropped[17], busy_res[18]
   input  wire logic        csr_wen,
   input  wire logic        csr_wdata
);
   import tps_pkg::*;

   logic           active_low_ff;
   logic           q_valid;
   req_cmd_type    q_cmd;
   logic           q_pop;
   rsp_fields_type fields;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff <= 1'b0;
      end else if (csr_wen) begin
         active_low_ff <= csr_wdata;
      end
   end

   tps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_data  (req_tdata),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   tps_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (q_cmd),
      .cmd_pop    (q_pop),
      .active_low (active_low_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_fields (fields)
   );

   assign rsp_tdata = {5'b00000, fields.busy_res, fields.dropped, fields.queue_count,
                       fields.idle_level, fields.tone_hz};

endmodule

`default_nettype wire

>>> tb/sv/tone_pattern_sequencer_test.sv
// Self-checking testbench for the buzzer tone pattern sequencer.
`timescale 1ns / 1ps

module tone_pattern_sequencer_test;
   import tps_pkg::*;

   localparam int QUEUE_DEPTH = 8;

   // Segment tables kept here, apart from the design's copy.
   localparam logic [5:0] SEQ_BASE [14] = '{
      6'd0, 6'd1, 6'd6, 6'd10, 6'd13, 6'd14, 6'd22, 6'd32, 6'd37, 6'd40, 6'd45, 6'd48,
      6'd51, 6'd54};
   localparam logic [3:0] SEQ_LEN [14] = '{
      4'd1, 4'd5, 4'd4, 4'd3, 4'd1, 4'd8, 4'd10, 4'd5, 4'd3, 4'd5, 4'd3, 4'd3, 4'd3, 4'd5};
   localparam logic [11:0] STEP_HZ [59] = '{
      12'd1000,
      12'd1000, 12'd0, 12'd1300, 12'd0, 12'd1600,
      12'd500, 12'd0, 12'd500, 12'd0,
      12'd1200, 12'd0, 12'd1500,
      12'd800,
      12'd2000, 12'd0, 12'd2000, 12'd0, 12'd2000, 12'd0, 12'd2000, 12'd0,
      12'd300, 12'd0, 12'd300, 12'd0, 12'd300, 12'd0, 12'd300, 12'd0, 12'd300, 12'd0,
      12'd600, 12'd0, 12'd1000, 12'd0, 12'd1400,
      12'd2000, 12'd0, 12'd2500,
      12'd1500, 12'd0, 12'd1000, 12'd0, 12'd600,
      12'd1100, 12'd0, 12'd1300,
      12'd1200, 12'd0, 12'd900,
      12'd1400, 12'd0, 12'd1400,
      12'd400, 12'd0, 12'd400, 12'd0, 12'd400};
   localparam logic [7:0] STEP_MS [59] = '{
      8'd50,
      8'd40, 8'd30, 8'd40, 8'd30, 8'd60,
      8'd50, 8'd50, 8'd50, 8'd50,
      8'd100, 8'd50, 8'd100,
      8'd150,
      8'd40, 8'd60, 8'd40, 8'd60, 8'd40, 8'd60, 8'd40, 8'd60,
      8'd80, 8'd40, 8'd80, 8'd40, 8'd80, 8'd40, 8'd80, 8'd40, 8'd80, 8'd40,
      8'd80, 8'd50, 8'd80, 8'd50, 8'd80,
      8'd50, 8'd50, 8'd50,
      8'd80, 8'd50, 8'd80, 8'd50, 8'd80,
      8'd50, 8'd30, 8'd60,
      8'd80, 8'd40, 8'd60,
      8'd70, 8'd60, 8'd70,
      8'd100, 8'd60, 8'd100, 8'd60, 8'd140};

   typedef struct {
      req_kind_type kind;
      logic [3:0]   pat;
      logic [1:0]   lvl;
      logic         mute;
   } buzzer_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;

   buzzer_req_type  backlog [$];
   rsp_fields_type  awaited [$];
   buzzer_req_type  on_bus;
   int              send_gap = 0;
   int              rsp_wait = 0;
   int              hold_left = 0;
   logic            hold_go = 1'b0;
   logic            hold_used = 1'b0;
   logic            idle_on = 1'b1;
   int              err_count = 0;

   // Mirror of the sequencer state.
   logic [3:0]  q_pat [QUEUE_DEPTH] = '{default: '0};
   logic [2:0]  q_head = '0;
   logic [3:0]  q_fill = '0;
   logic [31:0] now_ms = '0;
   logic        is_muted = 1'b0;
   alert_type   alert_lvl = ALERT_NONE;
   logic [31:0] alert_every = '0;
   logic [31:0] alert_at = '0;
   logic [3:0]  cur_seq = '0;
   logic [3:0]  seg_idx = '0;
   logic [7:0]  seg_left = '0;
   logic        playing = 1'b0;
   logic        alert_next = 1'b0;
   logic        pin_active_low = 1'b0;

   tone_pattern_sequencer #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void start_tone(logic [3:0] seq);
      cur_seq  = seq;
      seg_idx  = '0;
      seg_left = STEP_MS[SEQ_BASE[seq]];
      playing  = 1'b1;
   endfunction

   // Apply one request to the mirror and return the status it should report.
   function automatic rsp_fields_type buzzer_status_after(buzzer_req_type r);
      rsp_fields_type st;
      logic           drop;
      logic [1:0]     lvl;
      logic [31:0]    since;
      logic [2:0]     slot;
      logic [3:0]     p;
      drop = 1'b0;
      case (r.kind)
         REQ_TICK: begin
            now_ms = now_ms + 1;
            if (playing) begin
               if (seg_left != 0) seg_left = seg_left - 8'd1;
               if (seg_left == 0) begin
                  seg_idx = seg_idx + 4'd1;
                  if (seg_idx >= SEQ_LEN[cur_seq]) playing = 1'b0;
                  else seg_left = STEP_MS[SEQ_BASE[cur_seq] + seg_idx];
               end
            end
         end
         REQ_PLAY: begin
            if (!is_muted && r.pat <= MAX_PATTERN) begin
               if (q_fill >= QUEUE_DEPTH) begin
                  q_head = q_head + 3'd1;
                  q_fill = 4'(QUEUE_DEPTH - 1);
                  drop   = 1'b1;
               end
               slot = q_head + q_fill[2:0];
               q_pat[slot] = r.pat;
               q_fill = q_fill + 4'd1;
            end
         end
         REQ_ALERT: begin
            lvl = (r.lvl > ALERT_CRIT) ? ALERT_NONE : r.lvl;
            if (lvl != alert_lvl) begin
               alert_lvl   = alert_type'(lvl);
               alert_every = (lvl == ALERT_WARN) ? WARN_PERIOD_MS :
                             (lvl == ALERT_CRIT) ? CRIT_PERIOD_MS : 32'd0;
               alert_at    = now_ms;
            end
         end
         default: begin
            if (r.mute != is_muted) begin
               is_muted = r.mute;
               if (r.mute) begin
                  q_head   = '0;
                  q_fill   = '0;
                  playing  = 1'b0;
                  seg_left = '0;
               end
            end
         end
      endcase

      // An idle sequencer picks its next sound right away.
      if (!playing) begin
         since = now_ms - alert_at;
         if (alert_lvl != ALERT_NONE && !since[31] && (alert_next || q_fill == 0)) begin
            alert_at   = now_ms + alert_every;
            alert_next = 1'b0;
            if (!is_muted) start_tone(alert_lvl == ALERT_WARN ? SEQ_WARN : SEQ_CRIT);
         end else if (q_fill != 0 && !is_muted) begin
            p      = q_pat[q_head];
            q_head = q_head + 3'd1;
            q_fill = q_fill - 4'd1;
            start_tone(p);
            alert_next = 1'b1;
         end else begin
            alert_next = 1'b0;
         end
      end

      st.tone_hz     = playing ? STEP_HZ[SEQ_BASE[cur_seq] + seg_idx] : 12'd0;
      st.idle_level  = is_muted | pin_active_low;
      st.queue_count = q_fill;
      st.dropped     = drop;
      st.busy_res    = playing;
      return st;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited.push_back(buzzer_status_after(on_bus));
            send_gap = idle_on ? $urandom_range(0, 9) : 0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (backlog.size() != 0) begin
               on_bus = backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, on_bus.mute, on_bus.lvl, on_bus.pat};
               req_tuser  <= on_bus.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_used) begin
         hold_left <= 300;
         hold_used <= 1'b1;
      end
   end

   // Status monitor and checker.
   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_fields_type'(rsp_tdata[18:0]);
            if (awaited.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("status with no request outstanding: %h", rsp_tdata);
            end else begin
               want = awaited.pop_front();
               if (got.tone_hz !== want.tone_hz || got.idle_level !== want.idle_level ||
                   got.queue_count !== want.queue_count || got.dropped !== want.dropped ||
                   got.busy_res !== want.busy_res) begin
                  err_count++;
                  if (err_count <= 10)
                     $display({"status mismatch: exp hz=%0d idle=%0d qc=%0d drop=%0d",
                               " busy=%0d, got hz=%0d idle=%0d qc=%0d drop=%0d busy=%0d"},
                              want.tone_hz, want.idle_level, want.queue_count, want.dropped,
                              want.busy_res, got.tone_hz, got.idle_level, got.queue_count,
                              got.dropped, got.busy_res);
               end
            end
            rsp_wait = idle_on ? $urandom_range(0, 9) : 0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0) && (hold_left == 0);
      end
   end

   task automatic offer(req_kind_type kind, logic [3:0] pat, logic [1:0] lvl, logic mute);
      buzzer_req_type r;
      r.kind = kind;
      r.pat  = pat;
      r.lvl  = lvl;
      r.mute = mute;
      backlog.push_back(r);
   endtask

   // Wait until every request is answered, then let the pipeline drain.
   task automatic settle();
      int waited;
      waited = 0;
      while ((backlog.size() != 0 || req_tvalid || awaited.size() != 0) && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic set_polarity(logic v);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      pin_active_low = v;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // Ticks at the given percentage so patterns run through their segments; plays, alerts, mutes mixed in.
   task automatic random_burst(int n, int tick_pct);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < tick_pct) begin
            offer(REQ_TICK, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
         end else begin
            r = $urandom_range(0, 19);
            if (r < 14)
               offer(REQ_PLAY, ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15)) :
                     4'($urandom_range(0, 11)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
            else if (r < 17)
               offer(REQ_ALERT, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
            else
               offer(REQ_MUTE, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                     ($urandom_range(0, 2) == 0));
         end
      end
   endtask

   initial begin
      #30_000_000;
      $display("[tone_pattern_sequencer] ERROR");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, unknown codes, overflow, alert levels, mute paths.
      offer(REQ_TICK, 4'd0, 2'd0, 1'b0);
      offer(REQ_PLAY, 4'd0, 2'd0, 1'b0);
      offer(REQ_PLAY, 4'd15, 2'd3, 1'b1);
      offer(REQ_PLAY, 4'd12, 2'd0, 1'b0);
      for (int p = 4; p <= 11; p++) offer(REQ_PLAY, 4'(p), 2'd0, 1'b0);
      offer(REQ_PLAY, 4'd2, 2'd0, 1'b0);
      offer(REQ_ALERT, 4'd0, ALERT_CRIT, 1'b0);
      offer(REQ_ALERT, 4'd0, ALERT_CRIT, 1'b0);
      offer(REQ_ALERT, 4'd0, 2'd3, 1'b0);
      offer(REQ_ALERT, 4'd0, ALERT_WARN, 1'b0);
      offer(REQ_MUTE, 4'd0, 2'd0, 1'b1);
      offer(REQ_MUTE, 4'd0, 2'd0, 1'b1);
      offer(REQ_PLAY, 4'd3, 2'd0, 1'b0);
      offer(REQ_TICK, 4'd0, 2'd0, 1'b0);
      offer(REQ_MUTE, 4'd0, 2'd0, 1'b0);
      offer(REQ_MUTE, 4'd0, 2'd0, 1'b0);
      offer(REQ_TICK, 4'd0, 2'd0, 1'b0);
      settle();

      set_polarity(1'b1);
      random_burst(200, 80);
      settle();

      // Back-to-back requests while the receiver holds off.
      idle_on = 1'b0;
      hold_go = 1'b1;
      random_burst(300, 40);
      settle();

      set_polarity(1'b0);
      random_burst(300, 90);
      settle();

      set_polarity(1'b1);
      idle_on = 1'b1;
      random_burst(200, 75);
      settle();

      // Long tick runs with alerts set so alert sounds take turns with patterns.
      set_polarity(1'b0);
      offer(REQ_ALERT, 4'd0, ALERT_NONE, 1'b0);
      offer(REQ_ALERT, 4'd0, ALERT_CRIT, 1'b0);
      random_burst(500, 97);
      idle_on = 1'b0;
      offer(REQ_MUTE, 4'd0, 2'd0, 1'b0);
      offer(REQ_ALERT, 4'd0, ALERT_WARN, 1'b0);
      random_burst(500, 95);
      settle();

      if (awaited.size() != 0) err_count++;
      if (err_count == 0)
         $display("[tone_pattern_sequencer] OK");
      else
         $display("[tone_pattern_sequencer] ERROR");
      $finish;
   end

endmodule
